// File: rtl/core/spa_pkg.sv
// Shared types and constants of the slot pool allocator.
`default_nettype none

package spa_pkg;

    localparam int REL_W    = 10;
    localparam int BYTES_W  = 32;
    localparam int COUNT_W  = 11;
    localparam int BASE_W   = 48;
    localparam int ADDR_W   = 49;
    localparam int PROD_W   = REL_W + BYTES_W;
    localparam int CFG_W    = 48;
    localparam int CIDX_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 96;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_NO_SPACE    = 2'd2;
    localparam logic [1:0] ST_IGNORED     = 2'd3;

    localparam logic [CIDX_W-1:0] REG_POOL_ENABLED = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SLOT_BYTES   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SLOTS_IN_USE = 2'd2;
    localparam logic [CIDX_W-1:0] REG_POOL_BASE    = 2'd3;

    typedef struct packed {
        logic             opcode;
        logic [REL_W-1:0] release_index;
    } req_t;

    typedef struct packed {
        logic               pool_enabled;
        logic [BYTES_W-1:0] slot_bytes;
        logic [COUNT_W-1:0] slots_in_use;
        logic [BASE_W-1:0]  pool_base;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [REL_W-1:0]   slot_index;
        logic [ADDR_W-1:0]  slot_address;
        logic [BYTES_W-1:0] slot_length;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/spa_ram.sv
// Single-port-write memory with one registered read port and write-through forwarding.
`default_nettype none

module spa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/spa_engine.sv
// Allocation and release decision logic with the free-stack depth and fresh-slot counters.
`default_nettype none

module spa_engine import spa_pkg::*; #(
    parameter int NUM_SLOTS = 1024,
    parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    parameter int CW        = ($clog2(NUM_SLOTS + 1) > COUNT_W) ? $clog2(NUM_SLOTS + 1) : COUNT_W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clear,
    input  wire logic          fire,
    input  wire req_t          req,
    input  wire cfg_t          cfg,
    input  wire logic          busy_bit,
    input  wire logic [IW-1:0] stack_top,
    output res_t               res,
    output logic               stack_we,
    output logic      [IW-1:0] stack_waddr,
    output logic      [IW-1:0] stack_wdata,
    output logic      [IW-1:0] stack_raddr,
    output logic               busy_we,
    output logic      [IW-1:0] busy_waddr,
    output logic               busy_wdata
);

    logic [CW-1:0]     depth_reg, depth_next;
    logic [CW-1:0]     fresh_reg, fresh_next;
    logic [CW-1:0]     limit;
    logic [CW-1:0]     rel_ext;
    logic [CW-1:0]     slot;
    logic              held;
    logic              grant;
    logic [PROD_W-1:0] product;

    always_comb begin
        depth_next  = depth_reg;
        fresh_next  = fresh_reg;
        res         = '0;
        stack_we    = 1'b0;
        stack_waddr = IW'(depth_reg);
        stack_wdata = IW'(req.release_index);
        busy_we     = 1'b0;
        busy_waddr  = IW'(req.release_index);
        busy_wdata  = 1'b0;
        slot        = '0;
        grant       = 1'b0;
        product     = '0;
        limit   = (CW'(cfg.slots_in_use) > CW'(NUM_SLOTS)) ? CW'(NUM_SLOTS)
                                                             : CW'(cfg.slots_in_use);
        rel_ext = CW'(req.release_index);
        // A slot at or above the fresh count has not been handed out since the last clear.
        held    = (rel_ext < fresh_reg) && busy_bit;

        if (!cfg.pool_enabled) begin
            res.status = ST_UNSUPPORTED;
        end else if (req.opcode == OP_ALLOC) begin
            if (depth_reg != '0) begin
                slot       = CW'(stack_top);
                depth_next = depth_reg - CW'(1);
                grant      = 1'b1;
            end else if (fresh_reg < limit) begin
                slot       = fresh_reg;
                fresh_next = fresh_reg + CW'(1);
                grant      = 1'b1;
            end else begin
                res.status = ST_NO_SPACE;
            end
        end else begin
            res.slot_index = req.release_index;
            if ((rel_ext >= limit) || !held || (depth_reg >= CW'(NUM_SLOTS))) begin
                res.status = ST_IGNORED;
            end else begin
                res.status = ST_OK;
                depth_next = depth_reg + CW'(1);
                stack_we   = 1'b1;
                busy_we    = 1'b1;
                busy_wdata = 1'b0;
            end
        end

        if (grant) begin
            res.status       = ST_OK;
            res.slot_index   = REL_W'(slot);
            product          = PROD_W'(res.slot_index) * PROD_W'(cfg.slot_bytes);
            res.slot_address = ADDR_W'(cfg.pool_base) + ADDR_W'(product);
            res.slot_length  = cfg.slot_bytes;
            busy_we          = 1'b1;
            busy_waddr       = IW'(slot);
            busy_wdata       = 1'b1;
        end

        if (!fire) begin
            depth_next = depth_reg;
            fresh_next = fresh_reg;
            stack_we   = 1'b0;
            busy_we    = 1'b0;
        end
        if (clear) begin
            depth_next = '0;
            fresh_next = '0;
        end

        // The read register always holds the entry just below the next depth.
        stack_raddr = IW'(depth_next - CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            fresh_reg <= '0;
        end else begin
            depth_reg <= depth_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/slot_pool_allocator_top.sv
// Top level of the LIFO free-list slot pool allocator.
//
//  Channel  Ports                        Contents
//  s_       tvalid tready tdata tuser    request: tuser opcode, tdata release_index
//  m_       tvalid tready tdata          answer: status, slot_index, address, length
//  cfg_     wr_en index wdata            register writes, no read-back
//
// One transaction is taken every cycle while the result register is not stalled.
// The request register, the stack top register and the bitmap read register feed one
// decision stage that writes the result register.
// Reset clears the counters and the configuration; no clearing pass is needed.
// A configuration write empties the pool.
// A stalled result register holds the request register, and then the input stalls.
`default_nettype none

module slot_pool_allocator_top import spa_pkg::*; #(
    parameter int NUM_SLOTS = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // release_index[9:0], zero fill
    input  wire logic                s_tuser,   // opcode
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // status, slot_index, slot_address, slot_length
    input  wire logic                cfg_wr_en,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_wdata
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = ($clog2(NUM_SLOTS + 1) > COUNT_W) ? $clog2(NUM_SLOTS + 1) : COUNT_W;

    cfg_t          cfg_reg, cfg_next;
    logic          in_valid_reg, in_valid_next;
    req_t          in_req_reg;
    logic          out_valid_reg, out_valid_next;
    res_t          out_res_reg;
    logic          accept;
    logic          fire;
    res_t          res;
    logic          stack_we;
    logic [IW-1:0] stack_waddr;
    logic [IW-1:0] stack_wdata;
    logic [IW-1:0] stack_raddr;
    logic [IW-1:0] stack_top;
    logic          busy_we;
    logic [IW-1:0] busy_waddr;
    logic          busy_wdata;
    logic          busy_bit;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    assign in_valid_next  = accept || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POOL_ENABLED: cfg_next.pool_enabled = cfg_wdata[0];
                REG_SLOT_BYTES:   cfg_next.slot_bytes   = cfg_wdata[BYTES_W-1:0];
                REG_SLOTS_IN_USE: cfg_next.slots_in_use = cfg_wdata[COUNT_W-1:0];
                REG_POOL_BASE:    cfg_next.pool_base    = cfg_wdata[BASE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_req_reg.opcode        <= s_tuser;
            in_req_reg.release_index <= s_tdata[REL_W-1:0];
        end
        if (fire) begin
            out_res_reg <= res;
        end
    end

    spa_engine #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW),
        .CW        (CW)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (cfg_wr_en),
        .fire        (fire),
        .req         (in_req_reg),
        .cfg         (cfg_reg),
        .busy_bit    (busy_bit),
        .stack_top   (stack_top),
        .res         (res),
        .stack_we    (stack_we),
        .stack_waddr (stack_waddr),
        .stack_wdata (stack_wdata),
        .stack_raddr (stack_raddr),
        .busy_we     (busy_we),
        .busy_waddr  (busy_waddr),
        .busy_wdata  (busy_wdata)
    );

    spa_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_free_stack (
        .aclk    (aclk),
        .wr_en   (stack_we),
        .wr_addr (stack_waddr),
        .wr_data (stack_wdata),
        .rd_en   (1'b1),
        .rd_addr (stack_raddr),
        .rd_data (stack_top)
    );

    spa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_busy_map (
        .aclk    (aclk),
        .wr_en   (busy_we),
        .wr_addr (busy_waddr),
        .wr_data (busy_wdata),
        .rd_en   (accept),
        .rd_addr (IW'(s_tdata[REL_W-1:0])),
        .rd_data (busy_bit)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.slot_length, out_res_reg.slot_address,
                       out_res_reg.slot_index, out_res_reg.status};

endmodule

`default_nettype wire

// File: rtl/core/spa_checker.sv
// Port-level checks of the slot pool allocator and their binding to the top level.
`default_nettype none

module spa_checker import spa_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // A held result must stay offered until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped while the result was stalled");

    // The input only stalls when the result register is full and blocked.
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the result side could move");

    // Only a granted allocation carries an address and a length.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[92:12] == '0))
        else $error("failed request carries an address or a length");

    // No result is offered in the first cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind slot_pool_allocator_top spa_checker u_spa_checker (.*);

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the LIFO free-list slot pool allocator.
module tb;
    import spa_pkg::*;

    localparam int POOL_SLOTS = 1024;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 250;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = OP_ALLOC;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0] cfg_index = REG_POOL_ENABLED;
    logic [CFG_W-1:0] cfg_wdata = '0;

    slot_pool_allocator_top #(.NUM_SLOTS(POOL_SLOTS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the pool configuration and allocator state.
    logic               pool_on;
    logic [BYTES_W-1:0] pool_slot_bytes;
    logic [COUNT_W-1:0] pool_slot_count;
    logic [BASE_W-1:0]  pool_base_addr;
    logic [REL_W-1:0]   free_stack [POOL_SLOTS];
    int                 free_depth;
    int                 next_fresh;
    logic [POOL_SLOTS-1:0] slot_taken;

    req_t requests_todo[$];
    res_t answers_due[$];
    req_t next_req;
    req_t taken_req;
    res_t want;

    int send_idle_pct = 7;
    int recv_idle_pct = 68;
    logic hold_trigger = 1'b0;
    int hold_left;
    int quiet_cycles;
    int fail_count = 0;
    int requests_sent = 0;
    int settings_used = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic res_t serve_request(req_t rq);
        res_t r;
        int lim;
        logic [REL_W-1:0] slot;
        logic [63:0] addr;
        r = '0;
        lim = (pool_slot_count > POOL_SLOTS) ? POOL_SLOTS : int'(pool_slot_count);
        if (!pool_on) begin
            r.status = ST_UNSUPPORTED;
            return r;
        end
        if (rq.opcode == OP_ALLOC) begin
            if (free_depth > 0) begin
                free_depth--;
                slot = free_stack[free_depth];
            end else if (next_fresh < lim) begin
                slot = REL_W'(next_fresh);
                next_fresh++;
            end else begin
                r.status = ST_NO_SPACE;
                return r;
            end
            slot_taken[slot] = 1'b1;
            addr = 64'(pool_base_addr) + 64'(slot) * 64'(pool_slot_bytes);
            r.status = ST_OK;
            r.slot_index = slot;
            r.slot_address = addr[ADDR_W-1:0];
            r.slot_length = pool_slot_bytes;
            return r;
        end
        r.slot_index = rq.release_index;
        if (int'(rq.release_index) >= lim || !slot_taken[rq.release_index]
                || free_depth >= POOL_SLOTS) begin
            r.status = ST_IGNORED;
            return r;
        end
        slot_taken[rq.release_index] = 1'b0;
        free_stack[free_depth] = rq.release_index;
        free_depth++;
        r.status = ST_OK;
        return r;
    endfunction

    task automatic check_field(string fname, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", fname, want_v, got_v);
            fail_count++;
        end
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_POOL_ENABLED: pool_on = val[0];
            REG_SLOT_BYTES:   pool_slot_bytes = val[BYTES_W-1:0];
            REG_SLOTS_IN_USE: pool_slot_count = val[COUNT_W-1:0];
            REG_POOL_BASE:    pool_base_addr = val[BASE_W-1:0];
            default: ;
        endcase
        free_depth = 0;
        next_fresh = 0;
        slot_taken = '0;
    endtask

    task automatic set_pool(logic en, logic [BYTES_W-1:0] bytes, logic [COUNT_W-1:0] count,
                            logic [BASE_W-1:0] base);
        write_reg(REG_POOL_ENABLED, CFG_W'(en));
        write_reg(REG_SLOT_BYTES, CFG_W'(bytes));
        write_reg(REG_SLOTS_IN_USE, CFG_W'(count));
        write_reg(REG_POOL_BASE, CFG_W'(base));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [BASE_W-1:0] rand_base();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[BASE_W-1:0];
    endfunction

    task automatic queue_req(logic op, logic [REL_W-1:0] idx);
        req_t rq;
        rq.opcode = op;
        rq.release_index = idx;
        requests_todo.insert(requests_todo.size(), rq);
    endtask

    // Bursts of allocations alternate with bursts of releases aimed mostly at
    // managed slots, so the pool both fills up and drains through the stack.
    task automatic queue_random(int count, int span);
        req_t rq;
        bit release_burst;
        int k;
        release_burst = 1'b0;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(15) == 0)
                release_burst = !release_burst;
            if ($urandom_range(99) < 80)
                rq.opcode = release_burst ? OP_RELEASE : OP_ALLOC;
            else
                rq.opcode = release_burst ? OP_ALLOC : OP_RELEASE;
            if ($urandom_range(99) < 85)
                rq.release_index = REL_W'($urandom_range(span - 1));
            else
                rq.release_index = REL_W'($urandom_range(POOL_SLOTS - 1));
            requests_todo.insert(requests_todo.size(), rq);
        end
    endtask

    task automatic wait_drain();
        while (requests_todo.size() != 0 || s_tvalid || answers_due.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                taken_req.opcode = s_tuser;
                taken_req.release_index = s_tdata[REL_W-1:0];
                answers_due.insert(answers_due.size(), serve_request(taken_req));
                requests_sent++;
            end
            if (requests_todo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = requests_todo.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_req.opcode;
                s_tdata <= S_DATA_W'(next_req.release_index);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $error("result transaction with no request outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("status", 64'(want.status), 64'(m_tdata[1:0]));
                    check_field("slot_index", 64'(want.slot_index), 64'(m_tdata[11:2]));
                    check_field("slot_address", 64'(want.slot_address), 64'(m_tdata[60:12]));
                    check_field("slot_length", 64'(want.slot_length), 64'(m_tdata[92:61]));
                    status_seen[want.status]++;
                end
            end
            if (hold_trigger)
                hold_left <= LONG_HOLD;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            m_tready <= !hold_trigger && hold_left == 0 && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (requests_todo.size() == 0 && answers_due.size() == 0 && !s_tvalid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int p;
        int span;
        pool_on = 1'b0;
        pool_slot_bytes = '0;
        pool_slot_count = '0;
        pool_base_addr = '0;
        free_depth = 0;
        next_fresh = 0;
        slot_taken = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Three-slot pool at the widest size and highest base.
        set_pool(1'b1, 32'hFFFF_FFFF, 11'd3, 48'hFFFF_FFFF_FFFF);
        repeat (4) queue_req(OP_ALLOC, '0);
        queue_req(OP_RELEASE, 10'd1);
        queue_req(OP_RELEASE, 10'd1);
        queue_req(OP_RELEASE, 10'd3);
        queue_req(OP_RELEASE, 10'd1023);
        queue_req(OP_ALLOC, 10'd1023);
        queue_req(OP_RELEASE, 10'd0);
        queue_req(OP_RELEASE, 10'd2);
        repeat (3) queue_req(OP_ALLOC, '0);
        wait_drain();

        set_pool(1'b0, '0, 11'd1024, '0);
        queue_req(OP_ALLOC, '0);
        queue_req(OP_RELEASE, 10'd0);

        for (p = 0; p < 9; p++) begin
            wait_drain();
            if (p < 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 68;
            end else if (p < 6) begin
                send_idle_pct = 68;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: set_pool(1'b1, 32'd64, 11'd16, 48'h1000);
                1: set_pool(1'b1, 32'hFFFF_FFFF, 11'd8, 48'hFFFF_FFFF_FFFF);
                2: set_pool(1'b1, $urandom(), 11'd1024, rand_base());
                3: set_pool(1'b0, $urandom(), 11'd32, rand_base());
                4: set_pool(1'b1, '0, 11'd1, '0);
                5: set_pool(1'b1, $urandom(), 11'd0, rand_base());
                6: set_pool(1'b1, 32'($urandom_range(4096, 1)), 11'd64, rand_base());
                7: set_pool(1'b1, $urandom(), 11'($urandom_range(40, 2)), rand_base());
                default: set_pool(1'b1, $urandom(), 11'($urandom_range(1024, 1)), rand_base());
            endcase
            span = (pool_slot_count == 0 || pool_slot_count > POOL_SLOTS)
                   ? POOL_SLOTS : int'(pool_slot_count);
            if (p == 6) begin
                @(posedge aclk);
                hold_trigger <= 1'b1;
                @(posedge aclk);
                hold_trigger <= 1'b0;
            end
            if (p == 7) begin
                queue_random(107, span);
                wait_drain();
                queue_random(108, span);
            end else begin
                queue_random(215, span);
            end
        end

        wait_drain();
        repeat (10) @(posedge aclk);
        $display("Ran %0d requests over %0d pool settings, with stalls on both channels.",
                 requests_sent, settings_used);
        $display("Answers: %0d ok, %0d unsupported, %0d no space, %0d ignored releases.",
                 status_seen[ST_OK], status_seen[ST_UNSUPPORTED],
                 status_seen[ST_NO_SPACE], status_seen[ST_IGNORED]);
        if (fail_count == 0 && answers_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
